FILE: hw/rtl/rse_pkg.sv
// rse_pkg: shared constants, queue status type and GF(256) multiply
// for the reed-solomon parity encoder; no dependencies
`default_nettype none

package rse_pkg;

    localparam int MAX_PARITY_DEF = 30;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] PARITY_RESET = 5'd10;
    // field polynomial 0x11d with the x^8 term dropped
    localparam logic [7:0] GF_POLY_LOW = 8'h1D;
    localparam logic [7:0] GF_ALPHA = 8'h02;

    typedef struct packed {
        logic full;
        logic empty;
    } rse_qstat_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x = a;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/qr_reed_solomon_parity_encoder_top.sv
// qr_reed_solomon_parity_encoder_top: gf(256) reed-solomon parity encoder
// built from rse_front, rse_queue and rse_back; depends on rse_pkg
//
//   channel   ports                                   width  role
//   input     s_valid/s_ready/s_data_byte/s_block_end 8+1    data bytes
//   output    m_valid/m_ready/m_parity_byte/m_parity_last 8+1 parity bytes
//   config    cfg_wr_en/cfg_wr_data                   5      parity count
//
// one data byte per cycle through the lfsr while s_ready is high; one parity
// byte per cycle out of the serializer while m_ready is high, n per block.
// after reset or a config write the generator is rebuilt one root per
// cycle, with s_ready held low meanwhile (n = 10 after reset).
// the queue holds two finished blocks; s_ready also drops when it is full.
`default_nettype none

module qr_reed_solomon_parity_encoder_top import rse_pkg::*; #(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_block_end,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_parity_byte,
    output logic                  m_parity_last
);

    localparam int CW = $clog2(MAX_PARITY + 1);

    rse_qstat_t              q_stat;
    logic                    push;
    logic                    pop;
    logic [MAX_PARITY*8-1:0] push_data;
    logic [MAX_PARITY*8-1:0] head_data;
    logic [CW-1:0]           n_active;

    rse_front #(.MAX_PARITY(MAX_PARITY)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_block_end (s_block_end),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data),
        .n_active    (n_active)
    );

    rse_queue #(.MAX_PARITY(MAX_PARITY)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    rse_back #(.MAX_PARITY(MAX_PARITY)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .n_active      (n_active),
        .head_data     (head_data),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_parity_byte (m_parity_byte),
        .m_parity_last (m_parity_last)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rse_front.sv
// rse_front: generator builder and remainder lfsr; pushes the finished
// remainder of each block into the queue. depends on rse_pkg
`default_nettype none

module rse_front import rse_pkg::*; #(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [CFG_W-1:0]                  cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_data_byte,
    input  wire logic                              s_block_end,
    input  wire rse_qstat_t                        q_stat,
    output logic                                   push,
    output logic [MAX_PARITY*8-1:0]                push_data,
    output logic [$clog2(MAX_PARITY+1)-1:0]        n_active
);

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    logic [CW-1:0] n_reg;
    logic          build_reg;
    logic [IW-1:0] step_reg;
    logic [7:0]    root_reg;
    logic [7:0]    gen_reg [0:MAX_PARITY];
    logic [7:0]    gen_next [0:MAX_PARITY];
    logic [7:0]    rem_reg [0:MAX_PARITY-1];
    logic [7:0]    rem_fold [0:MAX_PARITY-1];
    logic [IW-1:0] n_m1;
    logic [7:0]    fb;
    logic          accept;

    function automatic logic [CW-1:0] clamp_count(input logic [CFG_W-1:0] v);
        logic [CW-1:0] r;
        if (v == '0) begin
            r = CW'(1);
        end else if (int'(v) > MAX_PARITY) begin
            r = CW'(MAX_PARITY);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    assign n_m1     = IW'(n_reg - CW'(1));
    assign n_active = n_reg;
    assign s_ready  = !build_reg && !q_stat.full;
    assign accept   = s_valid && s_ready;
    assign push     = accept && s_block_end;
    assign fb       = s_data_byte ^ rem_reg[n_m1];

    // one factor (x - alpha^i) folded in per cycle while build_reg is set
    always_comb begin
        for (int j = 0; j <= MAX_PARITY; j++) begin
            gen_next[j] = ((j > 0) ? gen_reg[(j > 0) ? j - 1 : 0] : 8'h00)
                          ^ gf_mul(gen_reg[j], root_reg);
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_PARITY; j++) begin
            if (CW'(j) < n_reg) begin
                rem_fold[j] = ((j > 0) ? rem_reg[(j > 0) ? j - 1 : 0] : 8'h00)
                              ^ gf_mul(fb, gen_reg[j]);
            end else begin
                rem_fold[j] = 8'h00;
            end
            push_data[j*8 +: 8] = rem_fold[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            n_reg     <= clamp_count(aresetn ? cfg_wr_data : PARITY_RESET);
            build_reg <= 1'b1;
            step_reg  <= '0;
            root_reg  <= 8'h01;
            for (int j = 0; j <= MAX_PARITY; j++) begin
                gen_reg[j] <= (j == 0) ? 8'h01 : 8'h00;
            end
            for (int j = 0; j < MAX_PARITY; j++) begin
                rem_reg[j] <= 8'h00;
            end
        end else begin
            if (build_reg) begin
                for (int j = 0; j <= MAX_PARITY; j++) begin
                    gen_reg[j] <= gen_next[j];
                end
                root_reg <= gf_mul(root_reg, GF_ALPHA);
                step_reg <= step_reg + IW'(1);
                if (step_reg == n_m1) begin
                    build_reg <= 1'b0;
                end
            end
            if (accept) begin
                for (int j = 0; j < MAX_PARITY; j++) begin
                    rem_reg[j] <= s_block_end ? 8'h00 : rem_fold[j];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rse_queue.sv
// rse_queue: two-entry queue of finished remainders between the lfsr
// front and the parity serializer. depends on rse_pkg
`default_nettype none

module rse_queue import rse_pkg::*; #(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      push,
    input  wire logic [MAX_PARITY*8-1:0]   push_data,
    input  wire logic                      pop,
    output logic [MAX_PARITY*8-1:0]        head_data,
    output rse_qstat_t                     q_stat
);

    localparam int DEPTH = 2;
    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [MAX_PARITY*8-1:0] entry_reg [0:DEPTH-1];
    logic [PW-1:0]           wr_ptr_reg;
    logic [PW-1:0]           rd_ptr_reg;
    logic [FW-1:0]           fill_reg;

    assign head_data = entry_reg[rd_ptr_reg];
    assign q_stat    = '{full: (fill_reg == FW'(DEPTH)), empty: (fill_reg == '0)};

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + FW'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rse_back.sv
// rse_back: walks the queue head highest degree first and drives the
// registered parity output. depends on rse_pkg
`default_nettype none

module rse_back import rse_pkg::*; #(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [$clog2(MAX_PARITY+1)-1:0]   n_active,
    input  wire logic [MAX_PARITY*8-1:0]           head_data,
    input  wire rse_qstat_t                        q_stat,
    output logic                                   pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_parity_byte,
    output logic                                   m_parity_last
);

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    logic          valid_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;
    logic [IW-1:0] cnt_reg;
    logic [IW-1:0] n_m1;
    logic [IW-1:0] idx;
    logic          load;
    logic          at_end;

    assign n_m1   = IW'(n_active - CW'(1));
    assign idx    = n_m1 - cnt_reg;
    assign at_end = (cnt_reg == n_m1);
    assign load   = !q_stat.empty && (!valid_reg || m_ready);
    assign pop    = load && at_end;

    assign m_valid       = valid_reg;
    assign m_parity_byte = byte_reg;
    assign m_parity_last = last_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head_data[idx*8 +: 8];
            last_reg <= at_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                cnt_reg   <= at_end ? '0 : cnt_reg + IW'(1);
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rse_checker.sv
// rse_checker: port-level assertions for the parity encoder top level,
// attached by bind; depends on qr_reed_solomon_parity_encoder_top
`default_nettype none

module rse_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       cfg_wr_en,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_parity_byte,
    input wire logic       m_parity_last
);

    // generator rebuild must block input right after reset
    a_ready_low_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready)
        else $error("s_ready high during generator build after reset");

    a_no_output_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("m_valid high right after reset");

    // a config write restarts the generator build
    a_ready_low_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("s_ready high right after config write");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_parity_byte)
                                && $stable(m_parity_last))
        else $error("stalled parity transfer changed");

endmodule

bind qr_reed_solomon_parity_encoder_top rse_checker u_rse_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_wr_en     (cfg_wr_en),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_parity_byte (m_parity_byte),
    .m_parity_last (m_parity_last)
);

`default_nettype wire

FILE: bench/testbench.sv
// testbench: self-checking bench for qr_reed_solomon_parity_encoder_top
// predicts parity bytes with its own gf(256) lfsr model; depends on rse_pkg
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rse_pkg::*;

    localparam int NPAR = MAX_PARITY_DEF;
    localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       block_end;
    } data_item_t;

    typedef struct packed {
        logic [7:0] parity;
        logic       is_last;
    } parity_item_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data_byte = 8'h00;
    logic             s_block_end = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [7:0]       m_parity_byte;
    logic             m_parity_last;

    qr_reed_solomon_parity_encoder_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_block_end  (s_block_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_parity_byte(m_parity_byte),
        .m_parity_last(m_parity_last)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [7:0] lfsr_rem [NPAR];
    logic [7:0] gen_coeff [NPAR+1];
    int         active_n;

    data_item_t   data_pending [$];
    parity_item_t parity_expected [$];
    data_item_t   next_item;
    parity_item_t got_item;

    int  items_queued = 0;
    int  items_accepted = 0;
    int  blocks_closed = 0;
    int  parity_checked = 0;
    int  config_writes = 0;
    int  errors = 0;
    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    int  src_gap_left = 0;
    int  sink_stall_left = 0;
    int  hold_left = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    bit  steady = 1'b0;

    // multiply in gf(256), msb of b first
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        int i;
        acc = 8'h00;
        for (i = 7; i >= 0; i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY_LOW : 8'h00);
            if (b[i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // load a parity count: clamp, clear the remainder, rebuild g(x)
    task automatic apply_parity_count(input logic [CFG_W-1:0] value);
        logic [7:0] root;
        int i;
        int j;
        active_n = (value == 0) ? 1 : ((value > NPAR) ? NPAR : int'(value));
        for (i = 0; i < NPAR; i++) begin
            lfsr_rem[i] = 8'h00;
        end
        for (i = 0; i <= NPAR; i++) begin
            gen_coeff[i] = 8'h00;
        end
        gen_coeff[0] = 8'h01;
        root = 8'h01;
        for (i = 0; i < active_n; i++) begin
            for (j = active_n; j > 0; j--) begin
                gen_coeff[j] = gen_coeff[j-1] ^ gf_product(gen_coeff[j], root);
            end
            gen_coeff[0] = gf_product(gen_coeff[0], root);
            root = gf_product(root, 8'h02);
        end
    endtask

    // shift one data byte into the remainder; on block end queue the parity bytes
    task automatic fold_data_byte(input logic [7:0] data, input logic block_end);
        logic [7:0] feedback;
        parity_item_t exp_item;
        int j;
        feedback = data ^ lfsr_rem[active_n-1];
        for (j = active_n - 1; j > 0; j--) begin
            lfsr_rem[j] = lfsr_rem[j-1] ^ gf_product(feedback, gen_coeff[j]);
        end
        lfsr_rem[0] = gf_product(feedback, gen_coeff[0]);
        if (block_end) begin
            for (j = 0; j < active_n; j++) begin
                exp_item.parity = lfsr_rem[active_n-1-j];
                exp_item.is_last = (j == active_n - 1);
                parity_expected.push_back(exp_item);
            end
            for (j = 0; j < NPAR; j++) begin
                lfsr_rem[j] = 8'h00;
            end
            blocks_closed++;
        end
    endtask

    // driver: one transfer per handshake, random idle bursts between items
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                fold_data_byte(s_data_byte, s_block_end);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap_left > 0) begin
                    src_gap_left--;
                    s_valid <= 1'b0;
                end else if (data_pending.size() != 0) begin
                    if (!steady && $urandom_range(99) < src_idle_pct) begin
                        src_gap_left = $urandom_range(1, 16) - 1;
                        s_valid <= 1'b0;
                    end else begin
                        next_item = data_pending.pop_front();
                        s_valid <= 1'b1;
                        s_data_byte <= next_item.data;
                        s_block_end <= next_item.block_end;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each parity transfer, stall the output at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_stall_left = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (parity_expected.size() == 0) begin
                    $display("%0t: unexpected parity transfer, actual byte %02h last %0b",
                             $time, m_parity_byte, m_parity_last);
                    errors++;
                end else begin
                    got_item = parity_expected.pop_front();
                    if (m_parity_byte !== got_item.parity) begin
                        $display("%0t: parity byte mismatch, expected %02h actual %02h",
                                 $time, got_item.parity, m_parity_byte);
                        errors++;
                    end
                    if (m_parity_last !== got_item.is_last) begin
                        $display("%0t: parity last mismatch, expected %0b actual %0b",
                                 $time, got_item.is_last, m_parity_last);
                        errors++;
                    end
                    parity_checked++;
                end
            end
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_ready <= 1'b0;
            end else if (!steady && $urandom_range(99) < sink_idle_pct) begin
                sink_stall_left = $urandom_range(1, 16) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic block_end);
        data_item_t item;
        item.data = value;
        item.block_end = block_end;
        data_pending.push_back(item);
        items_queued++;
    endtask

    task automatic push_block(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            push_byte(8'($urandom), i == len - 1);
        end
    endtask

    // all bytes taken, all parity seen, then room for bytes still in the lfsr
    task automatic wait_drained();
        while (items_accepted != items_queued || parity_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_parity_count(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_parity_count(value);
        config_writes++;
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    initial begin
        logic [CFG_W-1:0] cfg_plan [9];
        int ph;
        int count;
        int len;
        cfg_plan = '{5'd1, 5'd30, 5'd10, 5'd7, 5'd31, 5'd0, 5'd2,
                     CFG_W'($urandom_range(3, 29)), CFG_W'($urandom_range(3, 29))};
        apply_parity_count(PARITY_RESET);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset count: single zero byte, byte extremes, alternating bits
        src_idle_pct = 20;
        sink_idle_pct = 20;
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        wait_drained();

        // zero count behaves as one parity byte
        write_parity_count(5'd0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        wait_drained();

        // count above the maximum clamps
        write_parity_count(5'd31);
        push_block(3);
        // partial block, then a write restarts it
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'hFF, 1'b0);
        wait_drained();
        write_parity_count(5'd30);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h81, 1'b1);
        wait_drained();

        for (ph = 0; ph < 9; ph++) begin
            write_parity_count(cfg_plan[ph]);
            src_idle_pct = pick_idle_pct();
            sink_idle_pct = pick_idle_pct();
            count = 0;
            while (count < 31) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
                push_block(len);
                count += len;
            end
            // sometimes leave a block open across the next write
            if ($urandom_range(2) == 0) begin
                len = $urandom_range(1, 5);
                repeat (len) push_byte(8'($urandom), 1'b0);
            end
            wait_drained();
        end

        // back-pressure: output held off while input keeps coming
        write_parity_count(5'd30);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_requests++;
        repeat (10) push_block($urandom_range(2, 4));
        wait_drained();

        // closing stretch with no idling on either side
        write_parity_count(CFG_W'($urandom_range(1, 30)));
        steady = 1'b1;
        count = 0;
        while (count < 40) begin
            len = $urandom_range(1, 10);
            push_block(len);
            count += len;
        end
        wait_drained();

        $display("summary: %0d data bytes in %0d blocks, %0d parity bytes checked",
                 items_accepted, blocks_closed, parity_checked);
        $display("summary: %0d parity count writes incl. zero, max and clamped values",
                 config_writes);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d parity bytes outstanding", parity_expected.size());
        $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/rse_pkg.sv
hw/rtl/rse_front.sv
hw/rtl/rse_queue.sv
hw/rtl/rse_back.sv
hw/rtl/qr_reed_solomon_parity_encoder_top.sv
hw/rtl/rse_checker.sv
bench/testbench.sv
